[hdl/mtc_pkg.sv]
// Shared types, codes and sizes of the MSI table controller.
// No dependencies; every other file but mtc_ram refers to it by scoped names.
package mtc_pkg;

  localparam int NUM_ENTRIES = 32;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CFG_W       = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int ADDR_W      = 64;
  localparam int DATA_W      = 32;
  localparam int TGT_W       = ADDR_W + DATA_W;
  localparam int IN_FIELDS_W = 8 + 1 + ADDR_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + 1 + 1 + ADDR_W + DATA_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOORBELL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HI   = 2'd3;

  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_MSG    = 1'b1;

  typedef enum logic [2:0] {
    KIND_SET_STATE  = 3'd0,
    KIND_GET_STATE  = 3'd1,
    KIND_SET_TARGET = 3'd2,
    KIND_GET_TARGET = 3'd3,
    KIND_INJECT     = 3'd4,
    KIND_DOORBELL   = 3'd5,
    KIND_POLL       = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_NOT_SUPP  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_REPLY     = 3'd0,
    OP_SET_EN    = 3'd1,
    OP_GET_STATE = 3'd2,
    OP_SET_TGT   = 3'd3,
    OP_GET_TGT   = 3'd4,
    OP_INJECT    = 3'd5,
    OP_POLL      = 3'd6
  } op_e;

  typedef struct packed {
    op_e               op;
    status_e           status;
    logic [IDX_W-1:0]  idx;
    logic              enable;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    status_e           status;
    logic              enable;
    logic              pending;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

endpackage

[hdl/mtc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mtc_front.sv]
// Request front end: configuration registers, range and window checks, and
// translation of each request into a queued command. Uses mtc_pkg.
module mtc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mtc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [2:0]                        s_axis_tuser,
  input  logic                              full_i,
  output logic                              push_o,
  output mtc_pkg::cmd_t                     cmd_o,
  output logic [mtc_pkg::CFG_W-1:0]         live_n_o
);

  logic [mtc_pkg::CFG_W-1:0]  entries_q, doorbell_q;
  logic [mtc_pkg::ADDR_W-1:0] win_lo_q, win_hi_q;

  logic [7:0]                 entry_idx;
  logic                       enable_in;
  logic [mtc_pkg::ADDR_W-1:0] addr_in;
  logic [mtc_pkg::DATA_W-1:0] data_in;
  logic [mtc_pkg::CFG_W-1:0]  live_n;
  logic                       idx_ok, db_ok, out_of_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q  <= mtc_pkg::CFG_W'(32);
      doorbell_q <= mtc_pkg::CFG_W'(32);
      win_lo_q   <= '0;
      win_hi_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtc_pkg::REG_ENTRIES:  entries_q  <= cfg_wdata_i[mtc_pkg::CFG_W-1:0];
        mtc_pkg::REG_DOORBELL: doorbell_q <= cfg_wdata_i[mtc_pkg::CFG_W-1:0];
        mtc_pkg::REG_WIN_LO:   win_lo_q   <= cfg_wdata_i;
        mtc_pkg::REG_WIN_HI:   win_hi_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign entry_idx = s_axis_tdata[7:0];
  assign enable_in = s_axis_tdata[8];
  assign addr_in   = s_axis_tdata[8+mtc_pkg::ADDR_W:9];
  assign data_in   = s_axis_tdata[8+mtc_pkg::ADDR_W+mtc_pkg::DATA_W:9+mtc_pkg::ADDR_W];

  // clamp the entry count to the table size
  assign live_n = (entries_q > mtc_pkg::CFG_W'(mtc_pkg::NUM_ENTRIES)) ?
                  mtc_pkg::CFG_W'(mtc_pkg::NUM_ENTRIES) : entries_q;

  assign idx_ok     = entry_idx < 8'(live_n);
  assign db_ok      = doorbell_q < live_n;
  assign out_of_win = (addr_in < win_lo_q) || (addr_in > win_hi_q);

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = mtc_pkg::OP_REPLY;
    cmd_o.status = idx_ok ? mtc_pkg::ST_OK : mtc_pkg::ST_BAD_PARAM;
    cmd_o.idx    = entry_idx[mtc_pkg::IDX_W-1:0];
    cmd_o.enable = enable_in;
    cmd_o.addr   = addr_in;
    cmd_o.data   = data_in;
    case (s_axis_tuser)
      mtc_pkg::KIND_SET_STATE: begin
        if (idx_ok) cmd_o.op = mtc_pkg::OP_SET_EN;
      end
      mtc_pkg::KIND_GET_STATE: begin
        if (idx_ok) cmd_o.op = mtc_pkg::OP_GET_STATE;
      end
      mtc_pkg::KIND_SET_TARGET: begin
        if (idx_ok) begin
          if (out_of_win) begin
            cmd_o.status = mtc_pkg::ST_BAD_ADDR;
          end else begin
            cmd_o.op = mtc_pkg::OP_SET_TGT;
          end
        end
      end
      mtc_pkg::KIND_GET_TARGET: begin
        if (idx_ok) cmd_o.op = mtc_pkg::OP_GET_TGT;
      end
      mtc_pkg::KIND_INJECT: begin
        if (idx_ok) cmd_o.op = mtc_pkg::OP_INJECT;
      end
      mtc_pkg::KIND_DOORBELL: begin
        cmd_o.idx = doorbell_q[mtc_pkg::IDX_W-1:0];
        if (db_ok) begin
          cmd_o.op     = mtc_pkg::OP_INJECT;
          cmd_o.status = mtc_pkg::ST_OK;
        end else begin
          cmd_o.status = mtc_pkg::ST_NOT_SUPP;
        end
      end
      mtc_pkg::KIND_POLL: begin
        cmd_o.op     = mtc_pkg::OP_POLL;
        cmd_o.status = mtc_pkg::ST_OK;
      end
      default: begin
        cmd_o.status = mtc_pkg::ST_NOT_SUPP;
      end
    endcase
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign live_n_o      = live_n;

endmodule

[hdl/mtc_queue.sv]
// Short command queue between the front end and the table engine.
// Uses mtc_pkg for the command type and depth.
module mtc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output mtc_pkg::cmd_t head_o,
  output logic          empty_o
);

  localparam int PTR_W = (mtc_pkg::QUEUE_DEPTH > 1) ? $clog2(mtc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mtc_pkg::QUEUE_DEPTH + 1);

  mtc_pkg::cmd_t    slot_q [mtc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(mtc_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(mtc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(mtc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/mtc_back.sv]
// Table engine: entry flags, target RAM, scan sequencer and result register.
// Uses mtc_pkg and mtc_ram.
module mtc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mtc_pkg::cmd_t                    head_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  input  logic [mtc_pkg::CFG_W-1:0]        live_n_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mtc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int N = mtc_pkg::NUM_ENTRIES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                    state_q, state_d;
  mtc_pkg::cmd_t                 cmd_q, cmd_d;
  logic [N-1:0]                  en_q, en_d, pend_q, pend_d, vld_q, vld_d;
  logic [N-1:0]                  hits_q, hits_d;
  logic [mtc_pkg::IDX_W-1:0]     scan_q, scan_d;
  logic                          out_vld_q, out_vld_d;
  mtc_pkg::res_t                 res_q, res_d;

  logic [N-1:0]                  live_mask, inj_bit, scan_bit, hits_new;
  logic                          can_emit;
  logic                          ram_we;
  logic [mtc_pkg::IDX_W-1:0]     ram_raddr;
  logic [mtc_pkg::TGT_W-1:0]     ram_rdata;

  mtc_ram #(
    .WIDTH (mtc_pkg::TGT_W),
    .DEPTH (N)
  ) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_q.idx),
    .wdata_i ({cmd_q.addr, cmd_q.data}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < N; i++) begin
      live_mask[i] = mtc_pkg::CFG_W'(i) < live_n_i;
    end
  end

  assign can_emit = !out_vld_q || m_axis_tready;
  assign inj_bit  = (cmd_q.op == mtc_pkg::OP_INJECT) ?
                    ({{(N-1){1'b0}}, 1'b1} << cmd_q.idx) : '0;
  assign scan_bit = {{(N-1){1'b0}}, 1'b1} << scan_q;
  assign hits_new = en_q & (pend_q | inj_bit) & vld_q & live_mask;

  // keep the read address on the entry whose data the next state needs
  always_comb begin
    case (state_q)
      S_IDLE:  ram_raddr = head_i.idx;
      S_EXEC:  ram_raddr = cmd_q.idx;
      default: ram_raddr = scan_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    en_d      = en_q;
    pend_d    = pend_q;
    vld_d     = vld_q;
    hits_d    = hits_q;
    scan_d    = scan_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_emit) begin
          res_d        = '0;
          res_d.kind   = mtc_pkg::RES_STATUS;
          res_d.status = cmd_q.status;
          res_d.last   = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = S_IDLE;
          case (cmd_q.op)
            mtc_pkg::OP_SET_EN: begin
              en_d[cmd_q.idx] = cmd_q.enable;
            end
            mtc_pkg::OP_GET_STATE: begin
              res_d.enable  = en_q[cmd_q.idx];
              res_d.pending = pend_q[cmd_q.idx];
            end
            mtc_pkg::OP_SET_TGT: begin
              ram_we           = 1'b1;
              vld_d[cmd_q.idx] = 1'b1;
            end
            mtc_pkg::OP_GET_TGT: begin
              // an entry never written reads as zero
              if (vld_q[cmd_q.idx]) begin
                res_d.addr = ram_rdata[mtc_pkg::TGT_W-1:mtc_pkg::DATA_W];
                res_d.data = ram_rdata[mtc_pkg::DATA_W-1:0];
              end
            end
            mtc_pkg::OP_INJECT, mtc_pkg::OP_POLL: begin
              pend_d     = pend_q | inj_bit;
              hits_d     = hits_new;
              scan_d     = '0;
              res_d.last = hits_new == '0;
              if (hits_new != '0) state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if ((hits_q & scan_bit) != '0) begin
          state_d = S_EMIT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          res_d      = '0;
          res_d.kind = mtc_pkg::RES_MSG;
          res_d.addr = ram_rdata[mtc_pkg::TGT_W-1:mtc_pkg::DATA_W];
          res_d.data = ram_rdata[mtc_pkg::DATA_W-1:0];
          res_d.last = (hits_q & ~scan_bit) == '0;
          out_vld_d  = 1'b1;
          hits_d     = hits_q & ~scan_bit;
          pend_d     = pend_q & ~scan_bit;
          scan_d     = scan_q + 1'b1;
          state_d    = res_d.last ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      en_q      <= '0;
      pend_q    <= '0;
      vld_q     <= '0;
      hits_q    <= '0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      en_q      <= en_d;
      pend_q    <= pend_d;
      vld_q     <= vld_d;
      hits_q    <= hits_d;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {{(mtc_pkg::OUT_TDATA_W - mtc_pkg::OUT_FIELDS_W){1'b0}},
                          res_q.data, res_q.addr, res_q.pending, res_q.enable,
                          res_q.status};

  a_emit_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> hits_q[scan_q])
    else $error("emit state without a hit at the scan index");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> hits_q != '0)
    else $error("scan running with no hit left");

  a_hits_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hits_q & ~(vld_q & en_q & pend_q)) == '0)
    else $error("hit mask covers an entry that cannot fire");

  a_msg_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.kind == mtc_pkg::RES_MSG |->
      res_q.status == mtc_pkg::ST_OK && !res_q.enable && !res_q.pending)
    else $error("message write carries status fields");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_EXEC)
    else $error("popped command not executed");

endmodule

[hdl/msi_table_controller.sv]
// Top level of the MSI table controller: front end, command queue, table engine.
// Uses mtc_pkg, mtc_front, mtc_queue and mtc_back.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  s_axis   | in        | tvalid / tready        | tuser kind, tdata request fields
//  m_axis   | out       | tvalid / tready, tlast | tuser result kind, tdata result fields
//  cfg      | in        | cfg_we_i               | cfg_idx_i register, cfg_wdata_i value
//
// A request without a scan passes the engine's dequeue and execute states in order.
// Inject and poll then scan the entries up to and including the highest firing
// entry and emit one message write per firing entry; the scan sequencer steps
// through the single-read target RAM entry by entry.
// Reset clears all entry flags at once; the target RAM needs no clearing pass.
// A two-deep command queue accepts requests until full while the engine waits on m_axis.
module msi_table_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_idx[7:0], enable_in[8], target_addr_in[72:9], target_data_in[104:73]
  input  logic [mtc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[1:0], enable_out[2], pending_out[3], addr_out[67:4], data_out[99:68]
  output logic [mtc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // result_kind[0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  mtc_pkg::cmd_t             push_cmd, head_cmd;
  logic                      push, full, pop, empty;
  logic [mtc_pkg::CFG_W-1:0] live_n;

  mtc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .live_n_o      (live_n)
  );

  mtc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty)
  );

  mtc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .live_n_i      (live_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
